FILE: hdl/gbs_pkg.sv
`default_nettype none

package gbs_pkg;

	localparam int KIND_W     = 2;
	localparam int FIELD_W    = 8;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int DIV_W      = 8;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_REQUEST = 2'd0;
	localparam kind_t KIND_RELEASE = 2'd1;
	localparam kind_t KIND_EPOCH   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_EPOCH_CLR,
		ST_COUNT,
		ST_MOD,
		ST_SELECT,
		ST_REL_RD,
		ST_REL_APPLY,
		ST_FIN
	} gbs_state_t;

endpackage

`default_nettype wire

FILE: hdl/gbs_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module gbs_div #(
	parameter int DW = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gbs_pkg::DIV_W-1:0] dividend,
	input  logic [DW-1:0]             divisor,
	output logic                      busy,
	output logic                      done,
	output logic [gbs_pkg::DIV_W-1:0] quotient,
	output logic [DW-1:0]             remainder
);
	import gbs_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  num_q;
	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(diff) : DW'(trial);
			num_q <= {num_q[DIV_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

FILE: hdl/gbs_done_mem.sv
`default_nettype none

// one done bit per grid block, single port, registered read
module gbs_done_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);
	logic mem_q [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/grid_block_scheduler_unit.sv
`default_nettype none

// Sequence from accept to result: a request runs a count scan over the N = row count * column
//   count cells, an 8-step divide for the modulo and a selection scan (only the count scan with
//   nothing free); a release reads the done memory and divides; a new epoch clears GRID cells.
// Throughput: one item at a time, set by the done-memory scans and the shared divider.
// Reset: async, active low; afterwards a clearing pass over all MAX_ROW_BLOCKS*MAX_COL_BLOCKS
//   done-memory cells runs before the first item is taken.
module grid_block_scheduler_unit #(
	parameter int MAX_ROW_BLOCKS = 16,
	parameter int MAX_COL_BLOCKS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gbs_pkg::S_TDATA_W-1:0]  s_tdata,  // block_index, random_value
	input  logic [gbs_pkg::KIND_W-1:0]     s_tuser,  // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gbs_pkg::M_TDATA_W-1:0]  m_tdata,  // granted, granted_index, epoch_complete
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gbs_pkg::*;

	localparam int GRID   = MAX_ROW_BLOCKS * MAX_COL_BLOCKS;
	localparam int CELL_W = (GRID > 1) ? $clog2(GRID) : 1;
	localparam int CNT_W  = $clog2(GRID + 1);
	localparam int ROW_W  = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
	localparam int COL_W  = (MAX_COL_BLOCKS > 1) ? $clog2(MAX_COL_BLOCKS) : 1;
	localparam int ROWN_W = $clog2(MAX_ROW_BLOCKS + 1);
	localparam int COLN_W = $clog2(MAX_COL_BLOCKS + 1);

	gbs_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] row_cnt_q, col_cnt_q;
	logic [ROWN_W-1:0]     row_n;
	logic [COLN_W-1:0]     col_n;
	logic [CNT_W-1:0]      total;

	logic [MAX_ROW_BLOCKS-1:0] row_idle_q;
	logic [MAX_COL_BLOCKS-1:0] col_idle_q;
	logic [CNT_W-1:0]          done_cnt_q;

	logic [FIELD_W-1:0] bidx_q, rnd_q;
	logic               gnt_q;
	logic [FIELD_W-1:0] gidx_q;

	// scan issue side
	logic              issue_on_q;
	logic [CELL_W-1:0] idx_q;
	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [CELL_W-1:0] clr_q;
	// scan read-data side
	logic              v_s1;
	logic              last_s1;
	logic [CELL_W-1:0] idx_s1;
	logic [ROW_W-1:0]  r_s1;
	logic [COL_W-1:0]  c_s1;

	logic [CNT_W-1:0] cnt_q, cnt_next, seen_q, rank_q;

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic              accept;
	logic              issue;
	logic              issue_last;
	logic              cand;
	logic              hit;
	logic              clr_last;
	logic              bidx_ok;
	logic              epoch_done;

	logic              mem_we, mem_re, mem_wdata, mem_rdata;
	logic [CELL_W-1:0] mem_addr;

	logic               div_start, div_busy, div_done;
	logic [DIV_W-1:0]   div_dividend, div_quo;
	logic [CNT_W-1:0]   div_divisor, div_rem;

	always_comb begin
		if (row_cnt_q == '0) begin
			row_n = ROWN_W'(1);
		end else if (32'(row_cnt_q) > MAX_ROW_BLOCKS) begin
			row_n = ROWN_W'(MAX_ROW_BLOCKS);
		end else begin
			row_n = ROWN_W'(row_cnt_q);
		end
		if (col_cnt_q == '0) begin
			col_n = COLN_W'(1);
		end else if (32'(col_cnt_q) > MAX_COL_BLOCKS) begin
			col_n = COLN_W'(MAX_COL_BLOCKS);
		end else begin
			col_n = COLN_W'(col_cnt_q);
		end
		total = CNT_W'(row_n) * CNT_W'(col_n);
	end

	assign accept     = s_tvalid && s_tready;
	assign issue      = issue_on_q && (state_q == ST_COUNT || state_q == ST_SELECT);
	assign issue_last = CNT_W'(idx_q) == (total - CNT_W'(1));
	assign cand       = row_idle_q[r_s1] && col_idle_q[c_s1] && !mem_rdata;
	assign hit        = v_s1 && cand && (seen_q == rank_q);
	assign cnt_next   = cnt_q + CNT_W'(v_s1 && cand);
	assign clr_last   = clr_q == CELL_W'(GRID - 1);
	assign bidx_ok    = 16'(s_tdata[FIELD_W-1:0]) < 16'(total);
	assign epoch_done = done_cnt_q >= total;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_wdata    = 1'b0;
		mem_addr     = idx_q;
		div_start    = 1'b0;
		div_dividend = rnd_q;
		div_divisor  = cnt_next;
		case (state_q)
			ST_INIT_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						KIND_REQUEST: state_d = ST_COUNT;
						KIND_RELEASE: state_d = bidx_ok ? ST_REL_RD : ST_FIN;
						KIND_EPOCH:   state_d = ST_EPOCH_CLR;
						default:      state_d = ST_FIN;
					endcase
				end
			end
			ST_EPOCH_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_last) state_d = ST_FIN;
			end
			ST_COUNT: begin
				mem_re = issue;
				if (v_s1 && last_s1) begin
					if (cnt_next == '0) begin
						state_d = ST_FIN;
					end else begin
						div_start = 1'b1;
						state_d   = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (div_done) state_d = ST_SELECT;
			end
			ST_SELECT: begin
				mem_re = issue;
				if (hit) state_d = ST_FIN;
			end
			ST_REL_RD: begin
				mem_re       = 1'b1;
				mem_addr     = CELL_W'(bidx_q);
				div_start    = 1'b1;
				div_dividend = bidx_q;
				div_divisor  = CNT_W'(col_n);
				state_d      = ST_REL_APPLY;
			end
			ST_REL_APPLY: begin
				mem_addr = CELL_W'(bidx_q);
				if (div_done) begin
					mem_we    = !mem_rdata;
					mem_wdata = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= CFG_DATA_W'(16);
			col_cnt_q  <= CFG_DATA_W'(16);
			row_idle_q <= '1;
			col_idle_q <= '1;
			done_cnt_q <= '0;
			issue_on_q <= 1'b0;
			v_s1       <= 1'b0;
			idx_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			clr_q      <= '0;
			cnt_q      <= '0;
			seen_q     <= '0;
			gnt_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_ROW_COUNT) row_cnt_q <= cfg_data;
				if (cfg_index == CFG_COL_COUNT) col_cnt_q <= cfg_data;
			end

			if (accept) begin
				gnt_q      <= 1'b0;
				idx_q      <= '0;
				r_q        <= '0;
				c_q        <= '0;
				cnt_q      <= '0;
				clr_q      <= '0;
				issue_on_q <= (s_tuser == KIND_REQUEST);
				if (s_tuser == KIND_EPOCH) begin
					row_idle_q <= '1;
					col_idle_q <= '1;
					done_cnt_q <= '0;
				end
			end

			if (state_q == ST_INIT_CLR || state_q == ST_EPOCH_CLR) begin
				clr_q <= clr_q + CELL_W'(1);
			end

			v_s1 <= issue;
			if (issue) begin
				// a selection hit also stops the scan
				if (issue_last || (state_q == ST_SELECT && hit)) begin
					issue_on_q <= 1'b0;
				end else begin
					idx_q <= idx_q + CELL_W'(1);
					if (COLN_W'(c_q) == col_n - COLN_W'(1)) begin
						c_q <= '0;
						r_q <= r_q + ROW_W'(1);
					end else begin
						c_q <= c_q + COL_W'(1);
					end
				end
			end

			if (state_q == ST_COUNT) cnt_q <= cnt_next;

			if (state_q == ST_MOD && div_done) begin
				seen_q     <= '0;
				idx_q      <= '0;
				r_q        <= '0;
				c_q        <= '0;
				issue_on_q <= 1'b1;
			end

			if (state_q == ST_SELECT && v_s1 && cand) begin
				if (seen_q == rank_q) begin
					gnt_q            <= 1'b1;
					row_idle_q[r_s1] <= 1'b0;
					col_idle_q[c_s1] <= 1'b0;
				end else begin
					seen_q <= seen_q + CNT_W'(1);
				end
			end

			if (state_q == ST_REL_APPLY && div_done) begin
				row_idle_q[ROW_W'(div_quo)] <= 1'b1;
				col_idle_q[COL_W'(div_rem)] <= 1'b1;
				if (!mem_rdata) done_cnt_q <= done_cnt_q + CNT_W'(1);
			end

			if (state_q == ST_FIN && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bidx_q <= s_tdata[FIELD_W-1:0];
			rnd_q  <= s_tdata[2*FIELD_W-1:FIELD_W];
			gidx_q <= '0;
		end
		if (issue) begin
			idx_s1  <= idx_q;
			r_s1    <= r_q;
			c_s1    <= c_q;
			last_s1 <= issue_last;
		end
		if (state_q == ST_MOD && div_done) rank_q <= div_rem;
		if (state_q == ST_SELECT && hit) gidx_q <= FIELD_W'(idx_s1);
		if (state_q == ST_FIN && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {(M_TDATA_W - FIELD_W - 2)'(0), epoch_done, gidx_q, gnt_q};
		end
	end

	gbs_div #(
		.DW(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	gbs_done_mem #(
		.DEPTH(GRID),
		.AW   (CELL_W)
	) u_done_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	a_no_grant_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tdata_q[0]) |-> (m_tdata_q[FIELD_W:1] == '0))
		else $error("result without grant carries a nonzero index");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SELECT) |-> (seen_q <= rank_q))
		else $error("selection scan passed its rank");

	a_done_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done_cnt_q <= CNT_W'(GRID))
		else $error("done count exceeds grid size");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("item taken while divider busy");

endmodule

`default_nettype wire

FILE: tb/grid_block_scheduler_unit_test.sv
`timescale 1ns / 1ps

module grid_block_scheduler_unit_test;
	import gbs_pkg::*;

	localparam int GRID_MAX = 16;
	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 600;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam kind_t KIND_SPARE = 2'd3;

	typedef struct packed {
		logic       granted;
		logic [7:0] idx;
		logic       complete;
	} outcome_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] bidx;
		logic [7:0] rnd;
		outcome_t   outcome;
	} job_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // block_index, random_value
	kind_t                 s_tuser = KIND_REQUEST;   // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;   // granted, granted_index, epoch_complete
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	grid_block_scheduler_unit #(
		.MAX_ROW_BLOCKS(GRID_MAX),
		.MAX_COL_BLOCKS(GRID_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduler shadow state
	logic [CFG_DATA_W-1:0] row_cfg = 5'd16;
	logic [CFG_DATA_W-1:0] col_cfg = 5'd16;
	logic [GRID_MAX-1:0]   row_idle = '1;
	logic [GRID_MAX-1:0]   col_idle = '1;
	logic [CELLS-1:0]      done_map = '0;
	int                    done_total = 0;

	job_t       job_q[$];
	outcome_t   grant_q[$];
	logic [7:0] busy_blocks[$];
	int queued_total = 0;
	int results_seen = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int grants = 0;
	int refusals = 0;
	int completes = 0;
	int settings = 0;

	function automatic int used_count(logic [CFG_DATA_W-1:0] v);
		if (v == 0) return 1;
		if (v > GRID_MAX) return GRID_MAX;
		return int'(v);
	endfunction

	function automatic bit open_cell(int r, int c, int ncol);
		return row_idle[r] && col_idle[c] && !done_map[r * ncol + c];
	endfunction

	function automatic outcome_t schedule_step(kind_t kind, logic [7:0] bidx, logic [7:0] rnd);
		int nrow, ncol, cells, free, rank, seen, r, c;
		outcome_t res;
		nrow = used_count(row_cfg);
		ncol = used_count(col_cfg);
		cells = nrow * ncol;
		res = '0;
		free = 0;
		seen = 0;
		case (kind)
			KIND_REQUEST: begin
				for (r = 0; r < nrow; r++)
					for (c = 0; c < ncol; c++)
						if (open_cell(r, c, ncol)) free++;
				if (free != 0) begin
					rank = int'(rnd) % free;
					// taking a cell closes the rest of its row and column; the grant guard keeps it single
					for (r = 0; r < nrow; r++)
						for (c = 0; c < ncol; c++)
							if (!res.granted && open_cell(r, c, ncol)) begin
								if (seen == rank) begin
									row_idle[r] = 1'b0;
									col_idle[c] = 1'b0;
									res.granted = 1'b1;
									res.idx = 8'(r * ncol + c);
								end
								seen++;
							end
				end
			end
			KIND_RELEASE: begin
				if (int'(bidx) < cells) begin
					if (!done_map[bidx]) begin
						done_map[bidx] = 1'b1;
						done_total++;
					end
					row_idle[int'(bidx) / ncol] = 1'b1;
					col_idle[int'(bidx) % ncol] = 1'b1;
				end
			end
			KIND_EPOCH: begin
				row_idle = '1;
				col_idle = '1;
				done_map = '0;
				done_total = 0;
			end
			default: ;
		endcase
		res.complete = (done_total >= cells);
		return res;
	endfunction

	task automatic flag(string what, int want, int got);
		errors++;
		if (errors <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic offer(kind_t kind, logic [7:0] bidx, logic [7:0] rnd);
		job_t job;
		int i;
		job.kind = kind;
		job.bidx = bidx;
		job.rnd = rnd;
		job.outcome = schedule_step(kind, bidx, rnd);
		if (kind == KIND_REQUEST) begin
			if (job.outcome.granted) begin
				grants++;
				busy_blocks.insert(busy_blocks.size(), job.outcome.idx);
			end else begin
				refusals++;
			end
		end else if (kind == KIND_RELEASE) begin
			for (i = busy_blocks.size() - 1; i >= 0; i--)
				if (busy_blocks[i] == bidx) busy_blocks.delete(i);
		end else if (kind == KIND_EPOCH) begin
			busy_blocks.delete();
		end
		if (job.outcome.complete) completes++;
		job_q.insert(job_q.size(), job);
		queued_total++;
	endtask

	task automatic wait_drained();
		while (results_seen < queued_total) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROW_COUNT) row_cfg = val;
		else if (idx == CFG_COL_COUNT) col_cfg = val;
	endtask

	// mostly grant/release pairs on live blocks, with stray releases, spare kinds and resets
	task automatic random_burst(int n);
		int count, p, pick, cells;
		bit paused;
		count = 0;
		paused = 1'b0;
		while (count < n) begin
			if (!paused && count >= n / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			p = $urandom_range(99);
			cells = used_count(row_cfg) * used_count(col_cfg);
			if (done_total >= cells && $urandom_range(2) == 0) begin
				offer(KIND_EPOCH, 8'($urandom), 8'($urandom));
			end else if (p < 45 && busy_blocks.size() > 0) begin
				pick = $urandom_range(busy_blocks.size() - 1);
				offer(KIND_RELEASE, busy_blocks[pick], 8'($urandom));
			end else if (p < 80) begin
				offer(KIND_REQUEST, 8'($urandom), 8'($urandom));
			end else if (p < 88) begin
				offer(KIND_RELEASE, 8'($urandom), 8'($urandom));
			end else if (p < 93) begin
				offer(KIND_RELEASE, 8'($urandom_range(cells - 1)), 8'($urandom));
			end else if (p < 96) begin
				offer(KIND_SPARE, 8'($urandom), 8'($urandom));
				continue;
			end else begin
				offer(KIND_EPOCH, 8'($urandom), 8'($urandom));
			end
			count++;
		end
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
			int snd, int rcv, int n, bit squeeze);
		wait_drained();
		write_reg(CFG_ROW_COUNT, rows);
		write_reg(CFG_COL_COUNT, cols);
		settings++;
		send_idle_pct = snd;
		recv_stall_pct = rcv;
		if (squeeze) hold_len = HOLD_OFF_CYCLES;
		if ($urandom_range(1)) offer(KIND_EPOCH, 8'($urandom), 8'($urandom));
		random_burst(n);
	endtask

	// item driver
	job_t cur_job;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) grant_q.insert(grant_q.size(), cur_job.outcome);
			if (!s_tvalid || s_tready) begin
				if (job_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_job = job_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_job.rnd, cur_job.bidx};
					s_tuser <= cur_job.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	outcome_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (grant_q.size() == 0) begin
					flag("result with nothing pending", 0, int'(m_tdata));
				end else begin
					want = grant_q.pop_front();
					if (m_tdata[0] !== want.granted)
						flag("granted", want.granted, m_tdata[0]);
					if (m_tdata[8:1] !== want.idx)
						flag("granted_index", want.idx, m_tdata[8:1]);
					if (m_tdata[9] !== want.complete)
						flag("epoch_complete", want.complete, m_tdata[9]);
					if (m_tdata[M_TDATA_W-1:10] !== '0)
						flag("tdata padding", 0, m_tdata[M_TDATA_W-1:10]);
				end
			end
			if (hold_len > 0) begin
				hold_len--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else if (arst_n)
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", quiet);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// full 16x16 grid out of reset
		offer(KIND_REQUEST, 8'd0, 8'd0);
		offer(KIND_REQUEST, 8'd255, 8'd255);
		offer(KIND_RELEASE, 8'd0, 8'd0);
		offer(KIND_RELEASE, 8'd255, 8'd255);
		offer(KIND_SPARE, 8'd255, 8'd255);
		offer(KIND_EPOCH, 8'd0, 8'd0);
		offer(KIND_REQUEST, 8'd0, 8'd255);
		offer(KIND_RELEASE, 8'd255, 8'd0);
		offer(KIND_EPOCH, 8'd255, 8'd255);
		wait_drained();

		// single cell: no free block, out-of-range and repeated release
		write_reg(CFG_ROW_COUNT, 5'd1);
		write_reg(CFG_COL_COUNT, 5'd1);
		offer(KIND_REQUEST, 8'd0, 8'd0);
		offer(KIND_REQUEST, 8'd0, 8'd7);
		offer(KIND_RELEASE, 8'd0, 8'd0);
		offer(KIND_REQUEST, 8'd0, 8'd200);
		offer(KIND_RELEASE, 8'd1, 8'd0);
		offer(KIND_RELEASE, 8'd0, 8'd0);
		offer(KIND_SPARE, 8'd0, 8'd0);
		offer(KIND_EPOCH, 8'd0, 8'd0);
		wait_drained();

		// zero counts read as one
		write_reg(CFG_ROW_COUNT, 5'd0);
		write_reg(CFG_COL_COUNT, 5'd0);
		write_reg(CFG_SPARE, 5'd31);
		offer(KIND_REQUEST, 8'd0, 8'd255);
		offer(KIND_RELEASE, 8'd0, 8'd0);
		wait_drained();

		// oversized counts clamp to 16; done mark on cell 0 survives the resize
		write_reg(CFG_ROW_COUNT, 5'd31);
		write_reg(CFG_COL_COUNT, 5'd31);
		offer(KIND_REQUEST, 8'd0, 8'd128);
		offer(KIND_EPOCH, 8'd0, 8'd0);
		settings = 4;

		run_phase(5'd3, 5'd4, 0, 0, 50, 1'b0);
		run_phase(5'd2, 5'd2, 85, 0, 50, 1'b0);
		run_phase(5'd31, 5'd0, 0, 85, 40, 1'b0);
		run_phase(5'd0, 5'd5, 18, 18, 50, 1'b0);
		run_phase(5'd5, 5'd3, 0, 0, 40, 1'b1);
		run_phase(5'd16, 5'd16, 0, 85, 20, 1'b0);
		run_phase(5'd17, 5'd2, 18, 18, 50, 1'b0);
		run_phase(5'd4, 5'd6, 0, 0, 50, 1'b0);
		run_phase(5'd1, 5'd16, 85, 0, 40, 1'b0);
		run_phase(5'd8, 5'd8, 0, 85, 30, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (grant_q.size() != 0) flag("results never delivered", 0, grant_q.size());

		$display("Covered %0d items over %0d grid settings: %0d grants, %0d refusals,",
			queued_total, settings, grants, refusals);
		$display("  %0d results flagging a finished epoch, %0d mismatches", completes, errors);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: grid_block_scheduler_unit.f
hdl/gbs_pkg.sv
hdl/gbs_div.sv
hdl/gbs_done_mem.sv
hdl/grid_block_scheduler_unit.sv
tb/grid_block_scheduler_unit_test.sv
